>>> rtl/core/ffha_pkg.sv
package ffha_pkg;

    localparam int unsigned SIZE_W = 23;
    localparam int unsigned ADDR_W = 22;
    localparam int unsigned SUM_W  = 25;

    localparam logic [SUM_W-1:0] HEADER_BYTES = SUM_W'(8);
    localparam logic [SUM_W-1:0] PAD_BYTES    = SUM_W'(4);

    localparam logic [SIZE_W-1:0] START_RESET = 23'h001000;
    localparam logic [SIZE_W-1:0] WINDOW_END  = 23'h400000;
    localparam logic [SIZE_W-1:0] VALUE_MAX   = 23'h7FFFFF;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    localparam logic CFG_HEAP_START = 1'b0;
    localparam logic CFG_HEAP_LIMIT = 1'b1;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_ZERO     = 3'd1;
    localparam logic [2:0] ST_NO_MEM   = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_BAD_FREE = 3'd4;

    typedef struct packed {
        logic              kind;
        logic [SIZE_W-1:0] req_size;
        logic [ADDR_W-1:0] free_addr;
    } t_ffha_req;

    typedef struct packed {
        logic [ADDR_W-1:0] payload_addr;
        logic [2:0]        status;
        logic              reused;
        logic [SIZE_W-1:0] used_bytes;
    } t_ffha_rsp;

    typedef struct packed {
        logic              busy;
        logic [SIZE_W-1:0] size;
        logic [ADDR_W-1:0] base;
    } t_ffha_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CHECK,
        S_SUM,
        S_CARVE
    } t_ffha_state;

endpackage

>>> rtl/core/ffha_ram.sv
module ffha_ram #(
    parameter int unsigned WIDTH = 46,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/first_fit_heap_allocator_unit.sv
// A zero size request or a free on an empty table is answered straight from S_IDLE.
// Otherwise the walk steps S_READ and S_CHECK over the table entries in order until an
// entry is taken or the last one is checked; an allocation that finds none goes on to
// S_SUM and S_CARVE. One request at a time: the walk reads one table entry at a time
// from the RAM read port. The result is a one-cycle strobe that the receiver cannot stall.
// Reset restores heap_start and heap_limit to their defaults and empties the heap.
module first_fit_heap_allocator_unit
    import ffha_pkg::*;
#(
    parameter int unsigned MAX_BLOCKS = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  t_ffha_req         i_req,
    output logic              o_valid,
    output t_ffha_rsp         o_rsp,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [SIZE_W-1:0] i_cfg_data
);

    localparam int unsigned IDX_W = $clog2(MAX_BLOCKS);
    localparam int unsigned CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int unsigned ENT_W = $bits(t_ffha_entry);

    t_ffha_state       r_state, n_state;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [SIZE_W-1:0] r_top, n_top;
    logic [SIZE_W-1:0] r_used, n_used;
    logic [SIZE_W-1:0] r_heap_start, n_heap_start;
    logic [SIZE_W-1:0] r_heap_limit, n_heap_limit;
    logic              r_out_vld, n_out_vld;
    t_ffha_rsp         r_rsp, n_rsp;
    t_ffha_req         r_req, n_req;
    logic [SUM_W-1:0]  r_sum, n_sum;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    t_ffha_entry       ram_wdata;
    t_ffha_entry       ram_rdata;
    logic [ENT_W-1:0]  ram_rdata_raw;

    logic              accept;
    logic              hit;
    logic              last;
    logic [SIZE_W-1:0] lim;
    logic [SUM_W-1:0]  add_sum;
    logic [SUM_W-1:0]  sub_amt;
    logic [SUM_W-1:0]  top_next;

    ffha_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_BLOCKS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata_raw)
    );

    assign ram_rdata = t_ffha_entry'(ram_rdata_raw);
    assign busy      = (r_state != S_IDLE);
    assign accept    = start && !busy;
    assign o_valid   = r_out_vld;
    assign o_rsp     = r_rsp;
    assign last      = ((CNT_W'(r_idx) + CNT_W'(1)) == r_count);
    assign lim       = (r_heap_limit < WINDOW_END) ? r_heap_limit : WINDOW_END;

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_count      = r_count;
        n_top        = r_top;
        n_used       = r_used;
        n_heap_start = r_heap_start;
        n_heap_limit = r_heap_limit;
        n_out_vld    = 1'b0;
        n_rsp        = r_rsp;
        n_req        = r_req;
        n_sum        = r_sum;
        ram_we       = 1'b0;
        ram_waddr    = r_idx;
        ram_wdata    = ram_rdata;
        hit          = 1'b0;
        add_sum      = '0;
        sub_amt      = '0;
        top_next     = '0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_req = i_req;
                    n_idx = '0;
                    if (i_req.kind == KIND_ALLOC && i_req.req_size == '0) begin
                        n_rsp     = '{payload_addr: '0, status: ST_ZERO, reused: 1'b0,
                                      used_bytes: r_used};
                        n_out_vld = 1'b1;
                    end else if (r_count == '0) begin
                        if (i_req.kind == KIND_ALLOC) begin
                            n_state = S_SUM;
                        end else begin
                            n_rsp     = '{payload_addr: '0, status: ST_BAD_FREE,
                                          reused: 1'b0, used_bytes: r_used};
                            n_out_vld = 1'b1;
                        end
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (r_req.kind == KIND_ALLOC) begin
                    hit     = !ram_rdata.busy && (ram_rdata.size >= r_req.req_size);
                    add_sum = SUM_W'(r_used) + SUM_W'(r_req.req_size) + HEADER_BYTES;
                    if (hit) begin
                        ram_we         = 1'b1;
                        ram_wdata.busy = 1'b1;
                        n_used         = (add_sum > SUM_W'(VALUE_MAX)) ? VALUE_MAX
                                                                       : add_sum[SIZE_W-1:0];
                        n_rsp          = '{payload_addr: ADDR_W'(SUM_W'(ram_rdata.base)
                                                                 + HEADER_BYTES),
                                           status: ST_OK, reused: 1'b1, used_bytes: n_used};
                        n_out_vld      = 1'b1;
                        n_state        = S_IDLE;
                    end else if (last) begin
                        n_state = S_SUM;
                    end
                end else begin
                    hit     = ram_rdata.busy && ((SUM_W'(ram_rdata.base) + HEADER_BYTES)
                                                 == SUM_W'(r_req.free_addr));
                    sub_amt = SUM_W'(ram_rdata.size) + HEADER_BYTES;
                    if (hit) begin
                        ram_we         = 1'b1;
                        ram_wdata.busy = 1'b0;
                        n_used         = (SUM_W'(r_used) > sub_amt)
                                         ? SIZE_W'(SUM_W'(r_used) - sub_amt) : '0;
                        n_rsp          = '{payload_addr: '0, status: ST_OK, reused: 1'b0,
                                           used_bytes: n_used};
                        n_out_vld      = 1'b1;
                        n_state        = S_IDLE;
                    end else if (last) begin
                        n_rsp     = '{payload_addr: '0, status: ST_BAD_FREE, reused: 1'b0,
                                      used_bytes: r_used};
                        n_out_vld = 1'b1;
                        n_state   = S_IDLE;
                    end
                end
                if (!hit && !last) begin
                    n_idx   = r_idx + IDX_W'(1);
                    n_state = S_READ;
                end
            end
            S_SUM: begin
                n_sum   = SUM_W'(r_top) + SUM_W'(r_req.req_size) + HEADER_BYTES;
                n_state = S_CARVE;
            end
            S_CARVE: begin
                n_out_vld = 1'b1;
                n_state   = S_IDLE;
                top_next  = r_sum + PAD_BYTES;
                add_sum   = SUM_W'(r_used) + SUM_W'(r_req.req_size) + HEADER_BYTES
                            + PAD_BYTES;
                if (r_sum >= SUM_W'(lim)) begin
                    n_rsp = '{payload_addr: '0, status: ST_NO_MEM, reused: 1'b0,
                              used_bytes: r_used};
                end else if (r_count == CNT_W'(MAX_BLOCKS)) begin
                    n_rsp = '{payload_addr: '0, status: ST_FULL, reused: 1'b0,
                              used_bytes: r_used};
                end else begin
                    ram_we    = 1'b1;
                    ram_waddr = r_count[IDX_W-1:0];
                    ram_wdata = '{busy: 1'b1, size: r_req.req_size,
                                  base: r_top[ADDR_W-1:0]};
                    n_count   = r_count + CNT_W'(1);
                    n_top     = (top_next > SUM_W'(VALUE_MAX)) ? VALUE_MAX
                                                               : top_next[SIZE_W-1:0];
                    n_used    = (add_sum > SUM_W'(VALUE_MAX)) ? VALUE_MAX
                                                              : add_sum[SIZE_W-1:0];
                    n_rsp     = '{payload_addr: ADDR_W'(SUM_W'(r_top) + HEADER_BYTES),
                                  status: ST_OK, reused: 1'b0, used_bytes: n_used};
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (i_cfg_we) begin
            if (i_cfg_idx == CFG_HEAP_START) begin
                n_heap_start = i_cfg_data;
                n_top        = i_cfg_data;
                n_count      = '0;
                n_used       = '0;
            end else begin
                n_heap_limit = i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_top        <= START_RESET;
            r_used       <= '0;
            r_heap_start <= START_RESET;
            r_heap_limit <= WINDOW_END;
            r_out_vld    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_top        <= n_top;
            r_used       <= n_used;
            r_heap_start <= n_heap_start;
            r_heap_limit <= n_heap_limit;
            r_out_vld    <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_rsp <= n_rsp;
        r_req <= n_req;
        r_sum <= n_sum;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_BLOCKS))
        else $error("block count exceeds table depth");

    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (busy || o_valid))
        else $error("accepted request neither busy nor answered");

    a_reuse_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rsp.reused) |-> (o_rsp.status == ST_OK && o_rsp.payload_addr != '0))
        else $error("reused block without a granted payload");

    a_fail_no_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rsp.status != ST_OK) |-> (o_rsp.payload_addr == '0 && !o_rsp.reused))
        else $error("failed request carries an address");

    a_heap_start_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_top == r_heap_start))
        else $error("empty table with top pointer away from heap start");
`endif

endmodule

>>> verif/tb_first_fit_heap_allocator_unit.sv
module tb_first_fit_heap_allocator_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import ffha_pkg::*;

    localparam int unsigned MAX_BLOCKS = 64;
    localparam int unsigned HDR        = int'(HEADER_BYTES);
    localparam int unsigned PAD        = int'(PAD_BYTES);
    localparam int unsigned RAND_BEATS = 1950;

    class heap_scoreboard;
        logic [SIZE_W-1:0] start_addr;
        logic [SIZE_W-1:0] limit_addr;
        logic [SIZE_W-1:0] top;
        logic [SIZE_W-1:0] in_use;
        logic [ADDR_W-1:0] base_q [MAX_BLOCKS];
        logic [SIZE_W-1:0] size_q [MAX_BLOCKS];
        bit                busy_q [MAX_BLOCKS];
        int unsigned       n_blocks;
        t_ffha_rsp         pending [$];
        int unsigned       errors;
        int unsigned       carves;
        int unsigned       reuses;
        int unsigned       frees;
        int unsigned       by_status [5];

        function new();
            start_addr = START_RESET;
            limit_addr = WINDOW_END;
            clear_heap();
        endfunction

        function void clear_heap();
            top = start_addr;
            in_use = '0;
            n_blocks = 0;
            foreach (busy_q[i]) busy_q[i] = 1'b0;
        endfunction

        function void note_config(input logic idx, input logic [SIZE_W-1:0] value);
            if (idx == CFG_HEAP_START) begin
                start_addr = value;
                clear_heap();
            end else begin
                limit_addr = value;
            end
        endfunction

        function longint carve_room();
            longint lim;
            lim = (limit_addr < WINDOW_END) ? longint'(limit_addr) : longint'(WINDOW_END);
            return lim - longint'(top) - longint'(HDR);
        endfunction

        function bit pick_payload(input bit want_busy, output logic [ADDR_W-1:0] addr);
            int unsigned hits [$];
            for (int i = 0; i < n_blocks; i++) begin
                if (busy_q[i] == want_busy) hits.push_back(i);
            end
            if (hits.size() == 0) return 1'b0;
            addr = ADDR_W'(base_q[hits[$urandom_range(hits.size() - 1)]] + HDR);
            return 1'b1;
        endfunction

        function void grow(input longint unsigned amount);
            longint unsigned sum;
            sum = longint'(in_use) + amount;
            in_use = (sum > VALUE_MAX) ? VALUE_MAX : SIZE_W'(sum);
        endfunction

        function void note_request(input t_ffha_req r);
            t_ffha_rsp       rsp;
            bit              hit;
            longint unsigned lim;
            longint unsigned fin;
            longint unsigned cut;
            rsp = '0;
            rsp.status = ST_OK;
            hit = 1'b0;
            if (r.kind == KIND_ALLOC) begin
                if (r.req_size == '0) begin
                    rsp.status = ST_ZERO;
                end else begin
                    for (int i = 0; i < n_blocks; i++) begin
                        if (!hit && !busy_q[i] && size_q[i] >= r.req_size) begin
                            busy_q[i] = 1'b1;
                            rsp.payload_addr = ADDR_W'(base_q[i] + HDR);
                            rsp.reused = 1'b1;
                            grow(longint'(r.req_size) + HDR);
                            hit = 1'b1;
                            reuses++;
                        end
                    end
                    if (!hit) begin
                        lim = (limit_addr < WINDOW_END) ? limit_addr : WINDOW_END;
                        fin = longint'(top) + r.req_size + HDR;
                        if (fin >= lim) begin
                            rsp.status = ST_NO_MEM;
                        end else if (n_blocks >= MAX_BLOCKS) begin
                            rsp.status = ST_FULL;
                        end else begin
                            base_q[n_blocks] = top[ADDR_W-1:0];
                            size_q[n_blocks] = r.req_size;
                            busy_q[n_blocks] = 1'b1;
                            rsp.payload_addr = ADDR_W'(top + HDR);
                            n_blocks++;
                            top = (fin + PAD > VALUE_MAX) ? VALUE_MAX : SIZE_W'(fin + PAD);
                            grow(longint'(r.req_size) + PAD + HDR);
                            carves++;
                        end
                    end
                end
            end else begin
                for (int i = 0; i < n_blocks; i++) begin
                    if (!hit && busy_q[i] &&
                        longint'(base_q[i]) + HDR == longint'(r.free_addr)) begin
                        busy_q[i] = 1'b0;
                        cut = longint'(size_q[i]) + HDR;
                        in_use = (longint'(in_use) > cut) ? SIZE_W'(in_use - cut) : '0;
                        hit = 1'b1;
                        frees++;
                    end
                end
                if (!hit) rsp.status = ST_BAD_FREE;
            end
            rsp.used_bytes = in_use;
            by_status[rsp.status]++;
            pending.push_back(rsp);
        endfunction

        function void report_field(input string name, input logic [SIZE_W-1:0] want,
                                   input logic [SIZE_W-1:0] got);
            errors++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
        endfunction

        function void check_result(input t_ffha_rsp got);
            t_ffha_rsp want;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t: result beat with nothing expected, expected none, actual %p",
                         $time, got);
                return;
            end
            want = pending.pop_front();
            if (got.payload_addr !== want.payload_addr)
                report_field("payload_addr", want.payload_addr, got.payload_addr);
            if (got.status !== want.status)
                report_field("status", want.status, got.status);
            if (got.reused !== want.reused)
                report_field("reused", want.reused, got.reused);
            if (got.used_bytes !== want.used_bytes)
                report_field("used_bytes", want.used_bytes, got.used_bytes);
        endfunction
    endclass

    logic              i_clk      = 1'b0;
    logic              i_rst_n    = 1'b0;
    logic              start      = 1'b0;
    logic              busy;
    t_ffha_req         i_req      = '0;
    logic              o_valid;
    t_ffha_rsp         o_rsp;
    logic              i_cfg_we   = 1'b0;
    logic              i_cfg_idx  = CFG_HEAP_START;
    logic [SIZE_W-1:0] i_cfg_data = '0;

    heap_scoreboard sb = new();
    int unsigned    gap_pct = 10;
    int unsigned    rand_sent = 0;

    first_fit_heap_allocator_unit #(
        .MAX_BLOCKS(MAX_BLOCKS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_req(i_req),
        .o_valid(o_valid),
        .o_rsp(o_rsp),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1) sb.check_result(o_rsp);
    end

    task automatic send_request(input t_ffha_req r);
        while ($urandom_range(99) < gap_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy !== 1'b0);
        sb.note_request(r);
    endtask

    task automatic send_op(input logic kind, input longint unsigned size,
                           input longint unsigned addr);
        t_ffha_req r;
        r.kind = kind;
        r.req_size = SIZE_W'(size);
        r.free_addr = ADDR_W'(addr);
        send_request(r);
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        do @(posedge i_clk); while (sb.pending.size() != 0 || busy !== 1'b0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [SIZE_W-1:0] value);
        wait_idle();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        sb.note_config(idx, value);
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_ffha_req random_request(input int unsigned alloc_pct,
                                                 input int unsigned size_cap);
        t_ffha_req         r;
        logic [ADDR_W-1:0] addr;
        int unsigned       pick;
        longint            room;
        r.kind = KIND_ALLOC;
        r.req_size = SIZE_W'($urandom);
        r.free_addr = ADDR_W'($urandom);
        pick = $urandom_range(99);
        if ($urandom_range(99) < alloc_pct) begin
            room = sb.carve_room();
            if (pick < 5) begin
                r.req_size = SIZE_W'($urandom);
            end else if (pick < 10 && room > 1) begin
                r.req_size = SIZE_W'(room - 1 + $urandom_range(1));
            end else if (pick < 14) begin
                r.req_size = '0;
            end else if (pick < 30) begin
                r.req_size = SIZE_W'($urandom_range(size_cap * 16, 1));
            end else begin
                r.req_size = SIZE_W'($urandom_range(size_cap, 1));
            end
        end else begin
            r.kind = KIND_FREE;
            if (pick < 80 && sb.pick_payload(1'b1, addr)) begin
                r.free_addr = addr;
            end else if (pick < 92 && sb.pick_payload(1'b0, addr)) begin
                r.free_addr = addr;
            end
        end
        return r;
    endfunction

    task automatic run_phase(input logic [SIZE_W-1:0] heap_base,
                             input logic [SIZE_W-1:0] limit_value, input bit keep_heap,
                             input int unsigned beats, input int unsigned alloc_pct,
                             input int unsigned size_cap);
        write_reg(CFG_HEAP_LIMIT, limit_value);
        if (!keep_heap) write_reg(CFG_HEAP_START, heap_base);
        for (int n = 0; n < beats; n++) begin
            if (n == beats / 2) wait_idle();
            gap_pct = (rand_sent < RAND_BEATS / 3) ? 10 :
                      (rand_sent < 2 * RAND_BEATS / 3) ? 50 : 0;
            send_request(random_request(alloc_pct, size_cap));
            rand_sent++;
        end
    endtask

    initial begin
        #20_000_000;
        $display("status: fail");
        $finish;
    end

    initial begin
        longint room;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_op(KIND_ALLOC, 0, 0);
        send_op(KIND_FREE, 0, 0);
        send_op(KIND_ALLOC, 1, 0);
        send_op(KIND_ALLOC, 100, 0);
        send_op(KIND_FREE, 0, sb.base_q[0] + HDR);
        send_op(KIND_FREE, 0, sb.base_q[0] + HDR);
        send_op(KIND_ALLOC, 1, 0);
        send_op(KIND_FREE, 0, sb.base_q[1] + HDR);
        send_op(KIND_ALLOC, 50, 0);
        send_op(KIND_FREE, 0, sb.base_q[1] + HDR);
        send_op(KIND_ALLOC, 23'h400000, 0);
        send_op(KIND_ALLOC, 23'h7FFFFF, 22'h3FFFFF);
        send_op(KIND_FREE, 23'h7FFFFF, 22'h3FFFFF);
        room = sb.carve_room();
        send_op(KIND_ALLOC, room, 0);
        send_op(KIND_ALLOC, room - 1, 0);
        send_op(KIND_ALLOC, 1, 0);
        send_op(KIND_FREE, 0, sb.base_q[2] + HDR);
        send_op(KIND_ALLOC, 5, 0);
        send_op(KIND_FREE, 0, sb.base_q[2] + HDR);

        run_phase(START_RESET, WINDOW_END, 1'b0, 300, 60, 256);
        run_phase('0, WINDOW_END, 1'b0, 300, 55, 1024);
        run_phase(23'h3FF000, VALUE_MAX, 1'b0, 200, 60, 256);
        run_phase(23'h200000, 23'h200400, 1'b0, 250, 60, 48);
        run_phase('0, '0, 1'b1, 150, 50, 64);
        run_phase(WINDOW_END, WINDOW_END, 1'b0, 60, 60, 64);
        run_phase(VALUE_MAX, VALUE_MAX, 1'b0, 40, 60, 64);
        run_phase(START_RESET, 23'h3FFFFF, 1'b0, 650, 80, 512);

        wait_idle();
        repeat (2 * MAX_BLOCKS + 4) @(posedge i_clk);
        $display("Requests covered: %0d carves, %0d reuses, %0d good frees.",
                 sb.carves, sb.reuses, sb.frees);
        $display("Error statuses seen: zero %0d, no memory %0d, full %0d, bad free %0d.",
                 sb.by_status[ST_ZERO], sb.by_status[ST_NO_MEM], sb.by_status[ST_FULL],
                 sb.by_status[ST_BAD_FREE]);
        if (sb.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
